[hw/rtl/cosine_similarity_unit_defines.svh]
// Assertion macros for the cosine similarity unit checker.
// Included by the checker file; defines nothing but these macros.
`ifndef COSINE_SIMILARITY_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define CS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cos_sim_pkg.sv]
// Package for the cosine similarity unit: widths, constants and enum types.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package cos_sim_pkg;

  // Field widths
  localparam int ELEM_W   = 16;
  localparam int SIM_W    = 16;
  // Element bits that take part in the sums
  localparam int ELEM_BITS = 16;
  localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_W'((64'd1 << ELEM_BITS) - 64'd1);

  // Running sums and the shared multiplier
  localparam int ACC_W  = 42;
  localparam int LIMB   = 21;
  localparam int WIDE_W = 2 * ACC_W;     // normA * normB and dot^2
  localparam int Q_W    = 32;            // (2s - 1)^2
  localparam int LHS_W  = WIDE_W + Q_W + 2;
  localparam int SH_W   = 7;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [SIM_W-1:0] ONE_Q15 = SIM_W'(32768);

  typedef enum logic [2:0] {
    S_IDLE,   // take one element pair
    S_ELEM,   // three products into the running sums
    S_CHECK,  // zero vector test
    S_WIDE,   // normA * normB and dot * dot
    S_QSQ,    // square of the odd candidate
    S_LHS,    // candidate square times normA * normB
    S_CMP,    // compare and settle one result bit
    S_DONE    // hand result to the output register
  } state_t;

  typedef enum logic [2:0] {
    D_NONE,
    D_DOT,
    D_SQA,
    D_SQB,
    D_PROD,
    D_DSQ,
    D_Q,
    D_LHS
  } dst_t;

endpackage

`default_nettype wire

[hw/rtl/cos_sim_if.sv]
// Handshake channels of the cosine similarity unit: element pairs in, results out.
// Depends on cos_sim_pkg for the field widths.
`default_nettype none

interface cos_pair_if;
  import cos_sim_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] first_value;
  logic [ELEM_W-1:0] second_value;
  logic              is_last;

  modport source (output valid, output first_value, output second_value, output is_last,
                  input ready);
  modport sink   (input valid, input first_value, input second_value, input is_last,
                  output ready);
endinterface

interface cos_result_if;
  import cos_sim_pkg::*;

  logic             valid;
  logic             ready;
  logic [SIM_W-1:0] similarity;
  logic             defined;

  modport source (output valid, output similarity, output defined, input ready);
  modport sink   (input valid, input similarity, input defined, output ready);
endinterface

`default_nettype wire

[hw/rtl/cosine_similarity_unit.sv]
// Cosine similarity unit: streaming dot product and norms, exact Q1.15 result.
// Depends on cos_sim_pkg and the channel interfaces in cos_sim_if.sv.
//
// Usage:
//   pairs  : one beat per element pair (first_value, second_value, is_last).
//   result : one beat per vector pair, produced after the beat that carries is_last.
//            similarity is unsigned Q1.15 (32768 = 1.0); defined is 0 and
//            similarity 0 when either vector is all zero.
// Element pairs: pairs.ready drops after each taken pair while one shared
//   21x21 multiplier forms a*b, a*a and b*b in turn; no new pair is taken
//   until all three products are in the running sums.
// Last beat: a zero vector goes straight to the output register; otherwise
//   normA*normB and dot^2 are formed through the same multiplier, then one
//   result bit is settled per search step (16 bits, binary search by exact
//   squared compare); a cosine of exactly 1.0 ends after the first step.
// The running sums saturate at 2^42 - 1 and clear after each result.
// Reset clears the sums, the sequencer and the output register.
// A stalled result is held in the output register; element pairs keep being
//   taken meanwhile, and only a further result waits for it to drain.
`default_nettype none

module cosine_similarity_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  cos_pair_if.sink    pairs,
  cos_result_if.source result
);
  import cos_sim_pkg::*;

  state_t state, state_next;
  logic [3:0] step, step_next;

  // Element pair and running sums
  logic [ELEM_W-1:0] a_reg, b_reg;
  logic              last_reg;
  logic [ACC_W-1:0]  dot, sqa, sqb;

  // Final division operands and search state
  logic [WIDE_W-1:0] prod, dsq;
  logic [Q_W-1:0]    q;
  logic [LHS_W-1:0]  lhs;
  logic [SIM_W-1:0]  s_val, probe, cand, s_new;
  logic [SIM_W:0]    odd;
  logic              def_flag, pass, search_done;

  // Shared multiplier: issue operands, registered product, accumulate
  logic [LIMB-1:0]   op_x, op_y;
  logic [SH_W-1:0]   op_sh;
  dst_t              op_dst;
  logic [2*LIMB-1:0] mul_full, mul_p;
  logic [SH_W-1:0]   mul_sh;
  dst_t              mul_dst;
  logic [2:0]        lsum;
  logic [LHS_W-1:0]  acc_cur, acc_sum;
  logic [LHS_W:0]    acc_sum_full;
  logic [ACC_W-1:0]  acc_sat;

  // Output register
  logic             res_valid;
  logic [SIM_W-1:0] res_sim;
  logic             res_def;
  logic             accept, res_load;

  assign accept   = pairs.valid && pairs.ready;
  assign res_load = (state == S_DONE) && (!res_valid || result.ready);

  assign result.valid      = res_valid;
  assign result.similarity = res_sim;
  assign result.defined    = res_def;

  // Search candidate and its odd factor 2c - 1
  assign cand        = s_val | probe;
  assign odd         = {cand, 1'b0} - (SIM_W + 1)'(1);
  assign pass        = lhs <= LHS_W'({dsq, {Q_W{1'b0}}});
  assign s_new       = pass ? cand : s_val;
  assign search_done = probe[0] || (pass && probe[SIM_W-1]);

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next  = state;
    step_next   = step + 4'd1;
    pairs.ready = 1'b0;
    case (state)
      S_IDLE: begin
        pairs.ready = 1'b1;
        step_next   = '0;
        if (pairs.valid) state_next = S_ELEM;
      end
      S_ELEM: begin
        if (step == 4'd3) begin
          step_next  = '0;
          state_next = last_reg ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        step_next  = '0;
        state_next = (sqa == '0 || sqb == '0) ? S_DONE : S_WIDE;
      end
      S_WIDE: begin
        if (step == 4'd8) begin
          step_next  = '0;
          state_next = S_QSQ;
        end
      end
      S_QSQ: begin
        if (step == 4'd1) begin
          step_next  = '0;
          state_next = S_LHS;
        end
      end
      S_LHS: begin
        if (step == 4'd8) begin
          step_next  = '0;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        step_next  = '0;
        state_next = search_done ? S_DONE : S_QSQ;
      end
      S_DONE: begin
        step_next = '0;
        if (res_load) state_next = S_IDLE;
      end
      default: begin
        step_next  = '0;
        state_next = S_IDLE;
      end
    endcase
  end

  // Pick multiplier operands, shift and destination for this step
  always_comb begin
    op_x   = '0;
    op_y   = '0;
    op_dst = D_NONE;
    lsum   = '0;
    case (state)
      S_ELEM: begin
        case (step)
          4'd0: begin op_x = LIMB'(a_reg); op_y = LIMB'(b_reg); op_dst = D_DOT; end
          4'd1: begin op_x = LIMB'(a_reg); op_y = LIMB'(a_reg); op_dst = D_SQA; end
          4'd2: begin op_x = LIMB'(b_reg); op_y = LIMB'(b_reg); op_dst = D_SQB; end
          default: ;
        endcase
      end
      S_WIDE: begin
        if (!step[3]) begin
          lsum = {2'b0, step[1]} + {2'b0, step[0]};
          if (!step[2]) begin
            op_x   = step[1] ? sqa[ACC_W-1:LIMB] : sqa[LIMB-1:0];
            op_y   = step[0] ? sqb[ACC_W-1:LIMB] : sqb[LIMB-1:0];
            op_dst = D_PROD;
          end else begin
            op_x   = step[1] ? dot[ACC_W-1:LIMB] : dot[LIMB-1:0];
            op_y   = step[0] ? dot[ACC_W-1:LIMB] : dot[LIMB-1:0];
            op_dst = D_DSQ;
          end
        end
      end
      S_QSQ: begin
        if (step == 4'd0) begin
          op_x   = LIMB'(odd[SIM_W-1:0]);
          op_y   = LIMB'(odd[SIM_W-1:0]);
          op_dst = D_Q;
        end
      end
      S_LHS: begin
        if (!step[3]) begin
          lsum = {1'b0, step[2:1]} + {2'b0, step[0]};
          case (step[2:1])
            2'd0:    op_x = prod[LIMB-1:0];
            2'd1:    op_x = prod[2*LIMB-1:LIMB];
            2'd2:    op_x = prod[3*LIMB-1:2*LIMB];
            default: op_x = prod[4*LIMB-1:3*LIMB];
          endcase
          op_y   = step[0] ? LIMB'(q[Q_W-1:LIMB]) : q[LIMB-1:0];
          op_dst = D_LHS;
        end
      end
      default: ;
    endcase
    op_sh = SH_W'(lsum) * SH_W'(LIMB);
  end

  assign mul_full = op_x * op_y;

  // Add the registered product, shifted, into its destination
  always_comb begin
    case (mul_dst)
      D_DOT:   acc_cur = LHS_W'(dot);
      D_SQA:   acc_cur = LHS_W'(sqa);
      D_SQB:   acc_cur = LHS_W'(sqb);
      D_PROD:  acc_cur = LHS_W'(prod);
      D_DSQ:   acc_cur = LHS_W'(dsq);
      D_LHS:   acc_cur = lhs;
      default: acc_cur = '0;
    endcase
    acc_sum_full = {1'b0, acc_cur} + {1'b0, LHS_W'(mul_p) << mul_sh};
    acc_sum      = acc_sum_full[LHS_W-1:0];
    acc_sat      = (acc_sum > LHS_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_p  <= mul_full;
    mul_sh <= op_sh;
    if (rst) begin
      mul_dst   <= D_NONE;
      dot       <= '0;
      sqa       <= '0;
      sqb       <= '0;
      res_valid <= 1'b0;
    end else begin
      mul_dst <= op_dst;

      // Write back the shared adder
      case (mul_dst)
        D_DOT:   dot  <= acc_sat;
        D_SQA:   sqa  <= acc_sat;
        D_SQB:   sqb  <= acc_sat;
        D_PROD:  prod <= acc_sum[WIDE_W-1:0];
        D_DSQ:   dsq  <= acc_sum[WIDE_W-1:0];
        D_Q:     q    <= mul_p[Q_W-1:0];
        D_LHS:   lhs  <= acc_sum;
        default: ;
      endcase

      // Sequencer-driven loads and clears
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_reg    <= pairs.first_value & ELEM_MASK;
            b_reg    <= pairs.second_value & ELEM_MASK;
            last_reg <= pairs.is_last;
          end
        end
        S_CHECK: begin
          prod     <= '0;
          dsq      <= '0;
          s_val    <= '0;
          probe    <= ONE_Q15;
          def_flag <= !(sqa == '0 || sqb == '0);
        end
        S_QSQ: begin
          if (step == 4'd0) lhs <= '0;
        end
        S_CMP: begin
          s_val <= s_new;
          probe <= probe >> 1;
        end
        S_DONE: begin
          if (res_load) begin
            dot <= '0;
            sqa <= '0;
            sqb <= '0;
          end
        end
        default: ;
      endcase

      // Output register: load a finished result, drop it once taken
      if (res_load) begin
        res_valid <= 1'b1;
        res_sim   <= def_flag ? s_val : '0;
        res_def   <= def_flag;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cos_sim_checker.sv]
// Port-level checks for the cosine similarity unit, bound to the top level.
// Depends on cosine_similarity_unit_defines.svh for the assertion macros.
`default_nettype none
`include "cosine_similarity_unit_defines.svh"

module cos_sim_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] similarity,
  input wire logic        defined
);

  // Hold a stalled result and its payload
  `CS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(similarity) && $stable(defined), "result changed while stalled")

  // An undefined result carries zero similarity
  `CS_ASSERT_NOW(a_undef_zero, clk, rst, out_valid && !defined, similarity == 16'd0, "undefined result is not zero")

  // Similarity never exceeds one
  `CS_ASSERT_NOW(a_sim_range, clk, rst, out_valid, similarity <= 16'd32768, "similarity above one")

  // Each taken pair occupies the multiplier, so ready is low in the next cycle
  `CS_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready, "ready high right after a beat")

endmodule

bind cosine_similarity_unit cos_sim_checker u_cos_sim_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pairs.valid),
  .in_ready   (pairs.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .similarity (result.similarity),
  .defined    (result.defined)
);

`default_nettype wire

[tb/cos_sim_checker.sv]
// Scoreboard for the cosine similarity unit: watches both channels, predicts each result.
// Depends on cos_sim_pkg and the channel interfaces in cos_sim_if.sv.
`timescale 1ns / 1ps

module cos_sim_scoreboard (
  input  logic  clk,
  input  logic  rst,
  cos_pair_if   pairs,
  cos_result_if result,
  output int    error_count,
  output int    outstanding_results,
  output int    pair_count,
  output int    result_count,
  output int    undefined_count,
  output int    saturated_count
);
  import cos_sim_pkg::*;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic             defined;
  } cos_result_t;

  logic [ACC_W-1:0] dot_sum;
  logic [ACC_W-1:0] first_sq_sum;
  logic [ACC_W-1:0] second_sq_sum;
  cos_result_t      expected_results[$];

  // Add one product to a running sum, pinning it at the top instead of wrapping
  function automatic logic [ACC_W-1:0] add_saturating(logic [ACC_W-1:0] acc,
                                                      logic [31:0] product);
    logic [ACC_W:0] total;
    total = {1'b0, acc} + (ACC_W+1)'(product);
    return total[ACC_W] ? ACC_MAX : total[ACC_W-1:0];
  endfunction

  // Largest s in 0..32768 with s = 0 or (2s-1)^2 * na * nb <= (65536 * dot)^2,
  // i.e. 32768 * dot / sqrt(na * nb) rounded half up, found by bisection
  function automatic logic [SIM_W-1:0] q15_cosine(logic [ACC_W-1:0] dot,
                                                  logic [ACC_W-1:0] norm_a,
                                                  logic [ACC_W-1:0] norm_b);
    logic [127:0] norm_prod;
    logic [127:0] dot_sq;
    logic [127:0] lhs;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    logic [31:0]  odd;
    norm_prod = 128'(norm_a) * 128'(norm_b);
    dot_sq    = (128'(dot) << 16) * (128'(dot) << 16);
    lo = 32'd0;
    hi = 32'(ONE_Q15);
    while (lo < hi) begin
      mid = (lo + hi + 32'd1) >> 1;
      odd = 32'd2 * mid - 32'd1;
      lhs = norm_prod * 128'(odd * odd);
      if (lhs <= dot_sq) lo = mid;
      else hi = mid - 32'd1;
    end
    return SIM_W'(lo);
  endfunction

  always @(posedge clk) begin : watch
    logic [ELEM_W-1:0] first_elem;
    logic [ELEM_W-1:0] second_elem;
    cos_result_t       want;
    if (rst) begin
      dot_sum       = '0;
      first_sq_sum  = '0;
      second_sq_sum = '0;
      expected_results.delete();
    end else begin
      // Fold the accepted pair into the sums; a last beat yields one result
      if (pairs.valid && pairs.ready) begin
        pair_count++;
        first_elem    = pairs.first_value & ELEM_MASK;
        second_elem   = pairs.second_value & ELEM_MASK;
        dot_sum       = add_saturating(dot_sum, 32'(first_elem) * 32'(second_elem));
        first_sq_sum  = add_saturating(first_sq_sum, 32'(first_elem) * 32'(first_elem));
        second_sq_sum = add_saturating(second_sq_sum, 32'(second_elem) * 32'(second_elem));
        if (pairs.is_last) begin
          if (first_sq_sum == '0 || second_sq_sum == '0) begin
            want.similarity = '0;
            want.defined    = 1'b0;
            undefined_count++;
          end else begin
            want.similarity = q15_cosine(dot_sum, first_sq_sum, second_sq_sum);
            want.defined    = 1'b1;
          end
          if (dot_sum == ACC_MAX || first_sq_sum == ACC_MAX || second_sq_sum == ACC_MAX)
            saturated_count++;
          expected_results = {expected_results, want};
          dot_sum       = '0;
          first_sq_sum  = '0;
          second_sq_sum = '0;
        end
      end

      // Compare the accepted result with the oldest prediction
      if (result.valid && result.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: similarity %0d, defined %0b",
                 result.similarity, result.defined);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.similarity !== want.similarity) begin
            $error("similarity mismatch: expected %0d, actual %0d",
                   want.similarity, result.similarity);
            error_count++;
          end
          if (result.defined !== want.defined) begin
            $error("defined mismatch: expected %0b, actual %0b",
                   want.defined, result.defined);
            error_count++;
          end
        end
      end
    end
    outstanding_results = expected_results.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the cosine similarity unit testbench: clock, reset, pair stimulus, result sink.
// Depends on cos_sim_pkg, cos_sim_if.sv, the unit itself and tb/cos_sim_checker.sv.
`timescale 1ns / 1ps

module tb_top;
  import cos_sim_pkg::*;

  localparam int RANDOM_PAIRS  = 1950;
  localparam int SAT_LENGTH    = 1040;  // enough full-scale squares to pin a sum
  localparam int DRAIN_CYCLES  = 240;   // covers the longest final computation
  localparam int STALL_LIMIT   = 4000;

  typedef enum int {
    VEC_RANDOM,
    VEC_SAME,
    VEC_SCALED,
    VEC_DISJOINT,
    VEC_FIRST_ZERO,
    VEC_SECOND_ZERO
  } vector_style_t;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_HOLD
  } sink_mode_t;

  logic clk;
  logic rst;

  cos_pair_if   pairs_ch ();
  cos_result_if result_ch ();

  int error_count;
  int outstanding_results;
  int pair_count;
  int result_count;
  int undefined_count;
  int saturated_count;

  cosine_similarity_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .pairs  (pairs_ch),
    .result (result_ch)
  );

  cos_sim_scoreboard i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .pairs               (pairs_ch),
    .result              (result_ch),
    .error_count         (error_count),
    .outstanding_results (outstanding_results),
    .pair_count          (pair_count),
    .result_count        (result_count),
    .undefined_count     (undefined_count),
    .saturated_count     (saturated_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result sink: switch between open, random, periodic and held-off stretches
  logic        sink_ready = 1'b0;
  sink_mode_t  sink_mode  = SINK_OPEN;
  int unsigned mode_left  = 0;
  int unsigned period     = 2;

  assign result_ch.ready = sink_ready;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      mode_left = (sink_mode == SINK_HOLD) ? $urandom_range(5, 40) : $urandom_range(10, 120);
      period    = $urandom_range(2, 5);
    end
    mode_left--;
    case (sink_mode)
      SINK_OPEN:     sink_ready <= 1'b1;
      SINK_RANDOM:   sink_ready <= 1'($urandom_range(0, 1));
      SINK_PERIODIC: sink_ready <= (mode_left % period) == 0;
      default:       sink_ready <= (mode_left == 0);
    endcase
  end

  // Sender burst state
  int unsigned burst_left = 0;

  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return ELEM_W'($urandom_range(1, 15));
      3:       return ELEM_W'(1) << $urandom_range(0, ELEM_W - 1);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Present one pair at the falling edge and hold it until the unit takes it;
  // between bursts drop valid for a random gap
  task automatic send_pair(input logic [ELEM_W-1:0] first, input logic [ELEM_W-1:0] second,
                           input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        @(negedge clk);
        pairs_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    pairs_ch.valid        = 1'b1;
    pairs_ch.first_value  = first;
    pairs_ch.second_value = second;
    pairs_ch.is_last      = last;
    do @(posedge clk); while (!pairs_ch.ready);
  endtask

  task automatic send_vector(input int unsigned len, input vector_style_t style);
    logic [ELEM_W-1:0] first;
    logic [ELEM_W-1:0] second;
    int unsigned       shift;
    shift = $urandom_range(0, 3);
    for (int unsigned i = 0; i < len; i++) begin
      first  = pick_value();
      second = pick_value();
      case (style)
        VEC_SAME:        second = first;
        VEC_SCALED:      second = first >> shift;
        VEC_DISJOINT:    if (i % 2) first = '0; else second = '0;
        VEC_FIRST_ZERO:  first = '0;
        VEC_SECOND_ZERO: second = '0;
        default:         ;
      endcase
      send_pair(first, second, i == len - 1);
    end
  endtask

  // Long vector of full-scale first elements: its square sum pins at the top
  task automatic send_saturating_vector();
    logic [ELEM_W-1:0] second;
    for (int i = 0; i < SAT_LENGTH; i++) begin
      second = ($urandom_range(0, 3) == 0) ? ELEM_W'($urandom) : '1;
      send_pair('1, second, i == SAT_LENGTH - 1);
    end
  endtask

  // Abort when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pairs_ch.valid && pairs_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no beat accepted for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned   random_sent;
    int unsigned   len;
    bit            sat_done;
    vector_style_t style;
    rst                   = 1'b1;
    pairs_ch.valid        = 1'b0;
    pairs_ch.first_value  = '0;
    pairs_ch.second_value = '0;
    pairs_ch.is_last      = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: full scale, zero vectors, orthogonal and mirrored pairs
    send_pair(16'd1, 16'd1, 1'b1);
    send_pair('1, '1, 1'b1);
    send_pair(16'd0, 16'd1234, 1'b1);
    send_pair(16'd4321, 16'd0, 1'b1);
    send_pair(16'd0, 16'd0, 1'b1);
    send_pair(16'd5, 16'd0, 1'b0);
    send_pair(16'd0, 16'd9, 1'b1);
    send_pair('1, 16'd1, 1'b0);
    send_pair(16'd1, '1, 1'b1);
    send_pair(16'd3, 16'd4, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'd0, 16'd0, 1'b1);
    send_pair(16'd0, 16'd0, 1'b0);
    send_pair(16'd0, 16'd7, 1'b0);
    send_pair(16'd0, 16'd0, 1'b1);

    // Random vectors, mostly short, with one long saturating vector
    random_sent = 0;
    sat_done    = 1'b0;
    while (random_sent < RANDOM_PAIRS) begin
      if (!sat_done && random_sent >= 300) begin
        send_saturating_vector();
        random_sent += SAT_LENGTH;
        sat_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        case ($urandom_range(0, 11))
          0:       style = VEC_SAME;
          1:       style = VEC_SCALED;
          2:       style = VEC_DISJOINT;
          3:       style = VEC_FIRST_ZERO;
          4:       style = VEC_SECOND_ZERO;
          default: style = VEC_RANDOM;
        endcase
        send_vector(len, style);
        random_sent += len;
      end
    end

    @(negedge clk);
    pairs_ch.valid = 1'b0;

    // Drain outstanding results, then let any late beat show up
    while (outstanding_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Streamed %0d element pairs and checked %0d similarity results.",
             pair_count, result_count);
    $display("Of those, %0d had a zero vector and %0d had a saturated sum.",
             undefined_count, saturated_count);
    if (outstanding_results != 0)
      $error("%0d predicted results never arrived", outstanding_results);
    if (error_count == 0 && outstanding_results == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
